/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RMQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define RMQ_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

/* src/rmq_pkg.sv */
// Types and constants for the rotation matrix to quaternion core.
`default_nettype none
package rmq_pkg;
   localparam int DW    = 16;             // data width
   localparam int FB    = 14;             // fraction bits
   localparam int SW    = DW + 1;         // off-diagonal pair sum width
   localparam int RADW  = DW + 3;         // signed radicand width
   localparam int NW    = 32;             // square root operand width (even)
   localparam int ROOTW = NW / 2;
   localparam int REMW  = ROOTW + 3;
   localparam int SQW   = ROOTW + 1;      // s = 2 * root
   localparam int INVW  = DW - 1;         // reciprocal quotient bits
   localparam int DIVW  = SQW + INVW;
   localparam int PW    = SW + INVW + 1;  // product width

   localparam logic signed [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [SQW-1:0] SAT_LIMIT = SQW'(1) << (2 * FB - INVW);

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   typedef struct packed {
      logic signed [DW-1:0] m00;
      logic signed [DW-1:0] m01;
      logic signed [DW-1:0] m02;
      logic signed [DW-1:0] m10;
      logic signed [DW-1:0] m11;
      logic signed [DW-1:0] m12;
      logic signed [DW-1:0] m20;
      logic signed [DW-1:0] m21;
      logic signed [DW-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] qx;
      logic signed [DW-1:0] qy;
      logic signed [DW-1:0] qz;
      logic signed [DW-1:0] qw;
      logic [1:0]           branch;
      logic                 saturated;
   } rsp_type;

   // Classified job: branch, negative-radicand flag, radicand operand and the three pair sums in slot order.
   typedef struct packed {
      logic [1:0]           branch;
      logic                 flag;
      logic [NW-1:0]        rad;
      logic signed [SW-1:0] p0;
      logic signed [SW-1:0] p1;
      logic signed [SW-1:0] p2;
   } job_type;

   typedef struct packed {
      job_type              job;
      logic [REMW-1:0]      rem;
      logic [ROOTW-1:0]     root;
      logic [SQW-1:0]       s;
      logic                 divsat;
      logic [DIVW-1:0]      divr;
      logic [INVW-1:0]      inv;
      logic signed [PW-1:0] prod0;
      logic signed [PW-1:0] prod1;
      logic signed [PW-1:0] prod2;
   } pipe_type;
endpackage
`default_nettype wire

/* src/rmq_queue.sv */
// Small flop-based first-in first-out queue.
`default_nettype none
`include "assert_macros.svh"
module rmq_queue #(
   parameter type T     = logic,
   parameter int  DEPTH = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  wire T     wr_data,
   output logic      full,
   input  wire logic pop,
   output T          rd_data,
   output logic      empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   T                mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `RMQ_ASSERT(a_count_bound, count_ff <= (AW+1)'(DEPTH), "queue count exceeds depth")
   `RMQ_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1,
      "queue count did not grow on push")
   `RMQ_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count_ff == $past(count_ff) - 1'b1,
      "queue count did not shrink on pop")
endmodule
`default_nettype wire

/* src/rmq_front.sv */
// Front end: branch selection, radicand and off-diagonal pair sums.
`default_nettype none
module rmq_front (
   input  wire rmq_pkg::req_type req,
   output rmq_pkg::job_type      job
);
   logic signed [rmq_pkg::RADW-1:0] d0, d1, d2, one, trace, rad;
   logic signed [rmq_pkg::SW-1:0]   a01, a02, a12, s12, s20, s01;

   always_comb begin
      d0    = rmq_pkg::RADW'(req.m00);
      d1    = rmq_pkg::RADW'(req.m11);
      d2    = rmq_pkg::RADW'(req.m22);
      one   = rmq_pkg::RADW'(1) << rmq_pkg::FB;
      trace = d0 + d1 + d2;
      a01   = rmq_pkg::SW'(req.m01) + rmq_pkg::SW'(req.m10);
      a02   = rmq_pkg::SW'(req.m02) + rmq_pkg::SW'(req.m20);
      a12   = rmq_pkg::SW'(req.m12) + rmq_pkg::SW'(req.m21);
      s12   = rmq_pkg::SW'(req.m12) - rmq_pkg::SW'(req.m21);
      s20   = rmq_pkg::SW'(req.m20) - rmq_pkg::SW'(req.m02);
      s01   = rmq_pkg::SW'(req.m01) - rmq_pkg::SW'(req.m10);

      if (trace > 0) begin
         job.branch = rmq_pkg::BR_TRACE;
         rad = trace + one;
         job.p0 = s12; job.p1 = s20; job.p2 = s01;
      end else if (req.m00 > req.m11 && req.m00 > req.m22) begin
         job.branch = rmq_pkg::BR_X;
         rad = d0 - d1 - d2 + one;
         job.p0 = a01; job.p1 = a02; job.p2 = s12;
      end else if (req.m11 > req.m22) begin
         job.branch = rmq_pkg::BR_Y;
         rad = d1 - d0 - d2 + one;
         job.p0 = a01; job.p1 = a12; job.p2 = s20;
      end else begin
         job.branch = rmq_pkg::BR_Z;
         rad = d2 - d0 - d1 + one;
         job.p0 = a02; job.p1 = a12; job.p2 = s01;
      end

      // Clamp a negative radicand to zero.
      job.flag = rad[rmq_pkg::RADW-1];
      job.rad  = job.flag ? '0
               : rmq_pkg::NW'(rad[rmq_pkg::RADW-2:0]) << rmq_pkg::FB;
   end
endmodule
`default_nettype wire

/* src/rmq_back.sv */
// Back end: pipelined square root, reciprocal, scaling and saturation.
`default_nettype none
`include "assert_macros.svh"
module rmq_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire rmq_pkg::job_type job,
   output logic                  job_pop,
   input  wire logic             out_full,
   output logic                  out_push,
   output rmq_pkg::rsp_type      out_data
);
   localparam int SQ0 = 0;
   localparam int DV0 = rmq_pkg::ROOTW + 1;
   localparam int MUL = DV0 + rmq_pkg::INVW;
   localparam int NST = MUL + 2;

   rmq_pkg::pipe_type st_ff [NST];
   rmq_pkg::pipe_type st_in [NST];
   logic [NST-1:0]    vld_ff;
   logic              adv;

   function automatic logic [rmq_pkg::DW:0] scale(input logic signed [rmq_pkg::PW-1:0] p);
      logic [rmq_pkg::PW-1:0] mag;
      logic [rmq_pkg::PW-1:0] sh;
      logic [rmq_pkg::DW:0]   res;
      mag = p[rmq_pkg::PW-1] ? rmq_pkg::PW'(-p) : rmq_pkg::PW'(p);
      sh  = mag >> rmq_pkg::FB;
      if (p[rmq_pkg::PW-1]) begin
         if (sh > (rmq_pkg::PW'(1) << (rmq_pkg::DW - 1))) begin
            res = {1'b1, rmq_pkg::QMIN};
         end else begin
            res = {1'b0, rmq_pkg::DW'(-sh)};
         end
      end else if (sh > rmq_pkg::PW'(rmq_pkg::QMAX)) begin
         res = {1'b1, rmq_pkg::QMAX};
      end else begin
         res = {1'b0, sh[rmq_pkg::DW-1:0]};
      end
      return res;
   endfunction

   assign adv     = !out_full;
   assign job_pop = adv;

   // Load a fresh job.
   always_comb begin
      st_in[SQ0]     = '0;
      st_in[SQ0].job = job;
   end

   // One result bit of the square root per stage.
   for (genvar k = 0; k < rmq_pkg::ROOTW; k++) begin : g_sqrt
      localparam int REMW_L = rmq_pkg::REMW;
      logic [REMW_L-1:0] remsh, trial;
      always_comb begin
         st_in[k+1] = st_ff[k];
         remsh = {st_ff[k].rem[REMW_L-3:0],
                  st_ff[k].job.rad[rmq_pkg::NW-1-2*k -: 2]};
         trial = REMW_L'({st_ff[k].root, 2'b01});
         if (remsh >= trial) begin
            st_in[k+1].rem  = remsh - trial;
            st_in[k+1].root = {st_ff[k].root[rmq_pkg::ROOTW-2:0], 1'b1};
         end else begin
            st_in[k+1].rem  = remsh;
            st_in[k+1].root = {st_ff[k].root[rmq_pkg::ROOTW-2:0], 1'b0};
         end
      end
   end

   // Set up the reciprocal of s.
   always_comb begin
      st_in[DV0]        = st_ff[DV0-1];
      st_in[DV0].s      = {st_ff[DV0-1].root, 1'b0};
      st_in[DV0].divsat = (st_in[DV0].s <= rmq_pkg::SAT_LIMIT);
      st_in[DV0].divr   = rmq_pkg::DIVW'(1) << (2 * rmq_pkg::FB);
      st_in[DV0].inv    = '0;
   end

   // One quotient bit per stage, most significant first.
   for (genvar j = 0; j < rmq_pkg::INVW; j++) begin : g_div
      localparam int B = rmq_pkg::INVW - 1 - j;
      logic [rmq_pkg::DIVW-1:0] dsub;
      always_comb begin
         st_in[DV0+j+1] = st_ff[DV0+j];
         dsub = rmq_pkg::DIVW'(st_ff[DV0+j].s) << B;
         if (st_ff[DV0+j].divr >= dsub) begin
            st_in[DV0+j+1].divr   = st_ff[DV0+j].divr - dsub;
            st_in[DV0+j+1].inv[B] = 1'b1;
         end
      end
   end

   // Scale the pair sums by the reciprocal.
   logic signed [rmq_pkg::INVW:0] invs;
   always_comb begin
      st_in[MUL+1] = st_ff[MUL];
      invs = st_ff[MUL].divsat ? (rmq_pkg::INVW+1)'(rmq_pkg::QMAX)
                               : {1'b0, st_ff[MUL].inv};
      st_in[MUL+1].prod0 = rmq_pkg::PW'(st_ff[MUL].job.p0 * invs);
      st_in[MUL+1].prod1 = rmq_pkg::PW'(st_ff[MUL].job.p1 * invs);
      st_in[MUL+1].prod2 = rmq_pkg::PW'(st_ff[MUL].job.p2 * invs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], job_valid};
      end
   end

   for (genvar i = 0; i < NST; i++) begin : g_reg
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // Saturate and place the components by branch.
   logic [rmq_pkg::DW:0]   c0, c1, c2;
   logic [rmq_pkg::DW-1:0] diag;
   always_comb begin
      c0   = scale(st_ff[NST-1].prod0);
      c1   = scale(st_ff[NST-1].prod1);
      c2   = scale(st_ff[NST-1].prod2);
      diag = rmq_pkg::DW'(st_ff[NST-1].root >> 1);
      out_data.branch    = st_ff[NST-1].job.branch;
      out_data.saturated = st_ff[NST-1].job.flag | st_ff[NST-1].divsat
                         | c0[rmq_pkg::DW] | c1[rmq_pkg::DW] | c2[rmq_pkg::DW];
      case (st_ff[NST-1].job.branch)
         rmq_pkg::BR_TRACE: begin
            out_data.qx = c0[rmq_pkg::DW-1:0]; out_data.qy = c1[rmq_pkg::DW-1:0];
            out_data.qz = c2[rmq_pkg::DW-1:0]; out_data.qw = diag;
         end
         rmq_pkg::BR_X: begin
            out_data.qx = diag;                out_data.qy = c0[rmq_pkg::DW-1:0];
            out_data.qz = c1[rmq_pkg::DW-1:0]; out_data.qw = c2[rmq_pkg::DW-1:0];
         end
         rmq_pkg::BR_Y: begin
            out_data.qx = c0[rmq_pkg::DW-1:0]; out_data.qy = diag;
            out_data.qz = c1[rmq_pkg::DW-1:0]; out_data.qw = c2[rmq_pkg::DW-1:0];
         end
         default: begin
            out_data.qx = c0[rmq_pkg::DW-1:0]; out_data.qy = c1[rmq_pkg::DW-1:0];
            out_data.qz = diag;                out_data.qw = c2[rmq_pkg::DW-1:0];
         end
      endcase
   end

   assign out_push = vld_ff[NST-1] && adv;

   `RMQ_ASSERT_NEXT(a_stall_holds, !adv, vld_ff == $past(vld_ff),
      "back pipeline moved while stalled")
   `RMQ_ASSERT(a_no_push_full, !(out_push && out_full), "push into full result queue")
endmodule
`default_nettype wire

/* src/rotation_matrix_to_quaternion_core.sv */
// Top level of the rotation matrix to quaternion core.
// Throughput: one matrix per cycle while the result queue has room; the
// 16-stage square root and 15-stage reciprocal pipelines each take one item
// per cycle and all stall together when that queue is full.
// Reset: synchronous, active high; empties both queues and the pipeline valids.
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire rmq_pkg::req_type req_data,
   output logic                  empty,
   input  wire logic             pop,
   output rmq_pkg::rsp_type      rsp_data
);
   rmq_pkg::job_type job_cls, job_head;
   rmq_pkg::rsp_type out_data;
   logic             job_empty, job_pop;
   logic             out_full, out_push;

   // Classify the incoming matrix combinationally.
   rmq_front u_front (
      .req (req_data),
      .job (job_cls)
   );

   // Decouple the front from the arithmetic pipe; transfer into it on push.
   rmq_queue #(.T(rmq_pkg::job_type), .DEPTH(4)) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (job_cls),
      .full    (full),
      .pop     (job_pop),
      .rd_data (job_head),
      .empty   (job_empty)
   );

   // Advance the whole back pipe whenever the result queue has room.
   rmq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!job_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // Hold finished results until the consumer transfers them out.
   rmq_queue #(.T(rmq_pkg::rsp_type), .DEPTH(2)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .pop     (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

   `RMQ_ASSERT(a_diag_nonneg,
      empty || (rsp_data.branch != rmq_pkg::BR_TRACE) || !rsp_data.qw[rmq_pkg::DW-1],
      "trace branch produced negative w")
   `RMQ_ASSERT(a_rsp_known, empty || !$isunknown(rsp_data), "waiting result has unknown bits")
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the rotation matrix to quaternion core.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   localparam int LATENCY = 40;
   localparam int CYCLE_LIMIT = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             pop = 1'b0;
   logic             full;
   logic             empty;
   rmq_pkg::req_type req_data = '0;
   rmq_pkg::rsp_type rsp_data;

   rmq_pkg::rsp_type quat_queue[$];
   int      error_count = 0;
   int      matrix_count = 0;
   int      quat_count = 0;
   int      cycle_count = 0;
   int      branch_seen[4] = '{0, 0, 0, 0};
   int      sat_count = 0;
   bit      idle_enable = 1'b1;   // random gaps on both sides
   int      hold_off = 0;         // long stall of the receiver, in cycles

   rotation_matrix_to_quaternion_core uut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Clamp a wide value to the signed 16-bit range and note any clamp.
   function automatic logic signed [rmq_pkg::DW-1:0] clamp_q(longint v, ref bit sat);
      if (v > longint'(rmq_pkg::QMAX)) begin
         sat = 1'b1;
         return rmq_pkg::QMAX;
      end
      if (v < longint'(rmq_pkg::QMIN)) begin
         sat = 1'b1;
         return rmq_pkg::QMIN;
      end
      return v[rmq_pkg::DW-1:0];
   endfunction

   // Scale a pair sum by the reciprocal, truncating toward zero.
   function automatic logic signed [rmq_pkg::DW-1:0] scale_pair(longint a, longint inv,
                                                               ref bit sat);
      longint p;
      longint m;
      p = a * inv;
      m = (p < 0) ? -p : p;
      m = m >>> rmq_pkg::FB;
      return clamp_q((p < 0) ? -m : m, sat);
   endfunction

   function automatic longint isqrt(longint n);
      longint res;
      longint b;
      res = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Shepperd conversion of one matrix to the expected quaternion.
   function automatic rmq_pkg::rsp_type matrix_to_quat(rmq_pkg::req_type m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint tr, rad, root, s, inv, diag;
      bit sat;
      rmq_pkg::rsp_type q;
      a00 = m.m00; a01 = m.m01; a02 = m.m02;
      a10 = m.m10; a11 = m.m11; a12 = m.m12;
      a20 = m.m20; a21 = m.m21; a22 = m.m22;
      sat = 1'b0;
      tr = a00 + a11 + a22;
      if (tr > 0) begin
         q.branch = rmq_pkg::BR_TRACE; rad = tr + (longint'(1) << rmq_pkg::FB);
      end else if (a00 > a11 && a00 > a22) begin
         q.branch = rmq_pkg::BR_X; rad = a00 - a11 - a22 + (longint'(1) << rmq_pkg::FB);
      end else if (a11 > a22) begin
         q.branch = rmq_pkg::BR_Y; rad = a11 - a00 - a22 + (longint'(1) << rmq_pkg::FB);
      end else begin
         q.branch = rmq_pkg::BR_Z; rad = a22 - a00 - a11 + (longint'(1) << rmq_pkg::FB);
      end
      if (rad < 0) begin
         rad = 0;
         sat = 1'b1;
      end
      root = isqrt(rad << rmq_pkg::FB);
      s = root * 2;
      diag = clamp_q(root >> 1, sat);
      if (s == 0) begin
         inv = longint'(rmq_pkg::QMAX);
         sat = 1'b1;
      end else begin
         inv = (longint'(1) << (2 * rmq_pkg::FB)) / s;
         if (inv > longint'(rmq_pkg::QMAX)) begin
            inv = longint'(rmq_pkg::QMAX);
            sat = 1'b1;
         end
      end
      case (q.branch)
         rmq_pkg::BR_TRACE: begin
            q.qx = scale_pair(a12 - a21, inv, sat);
            q.qy = scale_pair(a20 - a02, inv, sat);
            q.qz = scale_pair(a01 - a10, inv, sat);
            q.qw = diag[rmq_pkg::DW-1:0];
         end
         rmq_pkg::BR_X: begin
            q.qx = diag[rmq_pkg::DW-1:0];
            q.qy = scale_pair(a01 + a10, inv, sat);
            q.qz = scale_pair(a02 + a20, inv, sat);
            q.qw = scale_pair(a12 - a21, inv, sat);
         end
         rmq_pkg::BR_Y: begin
            q.qx = scale_pair(a01 + a10, inv, sat);
            q.qy = diag[rmq_pkg::DW-1:0];
            q.qz = scale_pair(a12 + a21, inv, sat);
            q.qw = scale_pair(a20 - a02, inv, sat);
         end
         default: begin
            q.qx = scale_pair(a02 + a20, inv, sat);
            q.qy = scale_pair(a12 + a21, inv, sat);
            q.qz = diag[rmq_pkg::DW-1:0];
            q.qw = scale_pair(a01 - a10, inv, sat);
         end
      endcase
      q.saturated = sat;
      return q;
   endfunction

   // Cycle counter: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: drive pop at each edge, with random bursts of stall, and check
   // every transfer against the oldest expected quaternion.
   always @(posedge clock) begin
      rmq_pkg::rsp_type want;
      int burst;
      if (!reset && pop && !empty) begin
         quat_count <= quat_count + 1;
         if (quat_queue.size() == 0) begin
            error_count <= error_count + 1;
            $display("%0t: unexpected quaternion %h", $time, rsp_data);
         end else begin
            want = quat_queue.pop_front();
            branch_seen[want.branch] <= branch_seen[want.branch] + 1;
            if (want.saturated) sat_count <= sat_count + 1;
            if (rsp_data.qx !== want.qx || rsp_data.qy !== want.qy ||
                rsp_data.qz !== want.qz || rsp_data.qw !== want.qw ||
                rsp_data.branch !== want.branch ||
                rsp_data.saturated !== want.saturated) begin
               error_count <= error_count + 1;
               $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d br=%0d sat=%0b",
                        $time, want.qx, want.qy, want.qz, want.qw, want.branch,
                        want.saturated);
               $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d br=%0d sat=%0b",
                        $time, rsp_data.qx, rsp_data.qy, rsp_data.qz, rsp_data.qw,
                        rsp_data.branch, rsp_data.saturated);
            end
         end
      end
      // Decide pop for the next edge.
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         pop <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
         burst = $urandom_range(1, 10);
         hold_off <= burst - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Offer one matrix and hold it until the transfer; optionally idle first.
   task automatic send_matrix(rmq_pkg::req_type m);
      int gap;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 10);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= m;
      @(posedge clock);
      while (full) @(posedge clock);
      quat_queue.push_back(matrix_to_quat(m));
      matrix_count++;
   endtask

   task automatic release_bus;
      push <= 1'b0;
   endtask

   task automatic wait_drained;
      release_bus();
      while (quat_queue.size() != 0 && cycle_count < CYCLE_LIMIT) @(posedge clock);
   endtask

   function automatic rmq_pkg::req_type from_rows(int v[9]);
      rmq_pkg::req_type m;
      m = '{rmq_pkg::DW'(v[0]), rmq_pkg::DW'(v[1]), rmq_pkg::DW'(v[2]),
            rmq_pkg::DW'(v[3]), rmq_pkg::DW'(v[4]), rmq_pkg::DW'(v[5]),
            rmq_pkg::DW'(v[6]), rmq_pkg::DW'(v[7]), rmq_pkg::DW'(v[8])};
      return m;
   endfunction

   function automatic rmq_pkg::req_type random_matrix();
      logic [159:0] bits;
      rmq_pkg::req_type m;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
      m = bits[$bits(rmq_pkg::req_type)-1:0];
      return m;
   endfunction

   // Near-rotation: a signed permutation with small noise, so every branch
   // shows up with well-formed numbers.
   function automatic rmq_pkg::req_type rotation_like();
      int v[9];
      int perm;
      int sg;
      for (int i = 0; i < 9; i++) v[i] = $urandom_range(0, 3000) - 1500;
      perm = $urandom_range(0, 5);
      for (int r = 0; r < 3; r++) begin
         int c;
         c = (perm < 3) ? (r + perm) % 3 : (perm - r + 3) % 3;
         sg = $urandom_range(0, 1) ? 16384 : -16384;
         v[r * 3 + c] = sg - (sg > 0 ? $urandom_range(0, 4000) : -$urandom_range(0, 4000));
      end
      return from_rows(v);
   endfunction

   task automatic test_directed;
      int id[9] = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
      int rx[9] = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
      int ry[9] = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
      int rz[9] = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
      int tie[9] = '{0, 100, -200, 300, 0, 5, 7, 9, 0};
      int tie2[9] = '{-100, 1, 2, 3, -100, 4, 5, 6, -100};
      int neg[9] = '{-32768, 32767, -32768, 32767, 32767, 32767, -32768, -32768, 32767};
      int zr[9] = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
      int nr[9] = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
      int bigt[9] = '{32767, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 32767};
      int sm[9] = '{0, 32767, 32767, -32768, 0, 32767, -32768, -32768, 1};
      int big[9] = '{32767, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768};
      send_matrix(from_rows(id));
      send_matrix(from_rows(rx));
      send_matrix(from_rows(ry));
      send_matrix(from_rows(rz));
      send_matrix(from_rows(tie));
      send_matrix(from_rows(tie2));
      send_matrix(from_rows(neg));
      send_matrix(from_rows(zr));
      send_matrix(from_rows(nr));
      send_matrix(from_rows(bigt));
      send_matrix(from_rows(sm));
      send_matrix(from_rows(big));
      send_matrix('0);
      send_matrix('1);
      send_matrix({9{16'h8000}});
      send_matrix({9{16'h7fff}});
      send_matrix({9{16'h5555}});
      send_matrix({9{16'haaaa}});
      wait_drained();
   endtask

   // Receiver stalls for a long stretch while matrices keep coming.
   task automatic test_backpressure;
      // Load the stall between edges so the receiver's own update cannot override it.
      @(negedge clock);
      hold_off = 300;
      @(posedge clock);
      for (int i = 0; i < 120; i++) send_matrix(rotation_like());
      wait_drained();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) != 0) send_matrix(rotation_like());
         else send_matrix(random_matrix());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(600);
      wait_drained();          // sender pauses until all results are back
      idle_enable = 1'b0;      // full rate for the last part
      test_random(350);
      wait_drained();
      repeat (LATENCY) @(posedge clock);
      $display("Converted %0d matrices, checked %0d quaternions, %0d saturated",
               matrix_count, quat_count, sat_count);
      $display("Branches trace/x/y/z: %0d/%0d/%0d/%0d", branch_seen[0], branch_seen[1],
               branch_seen[2], branch_seen[3]);
      if (error_count == 0 && quat_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* rotation_matrix_to_quaternion_core.f */
+incdir+src
src/rmq_pkg.sv
src/rmq_queue.sv
src/rmq_front.sv
src/rmq_back.sv
src/rotation_matrix_to_quaternion_core.sv
tb/sv/testbench.sv
